// ===== design/lqm_pkg.sv =====
// ----------------------------------------------------------------------------
// lqm_pkg: shared types and constants of the link quality monitor
// Event codes, register indexes, the configuration, state and result structs.
// ----------------------------------------------------------------------------
package lqm_pkg;

  localparam int unsigned QualW  = 10;
  localparam int unsigned RunW   = 8;
  localparam int unsigned BarsW  = 3;
  localparam int unsigned MacW   = 48;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [QualW-1:0] QualFull = 10'd1000;
  localparam logic [RunW-1:0]  RunMax   = 8'hFF;

  // Register reset values
  localparam logic [QualW-1:0] Bar4Rst = 10'd800;
  localparam logic [QualW-1:0] Bar3Rst = 10'd600;
  localparam logic [QualW-1:0] Bar2Rst = 10'd400;
  localparam logic [QualW-1:0] Bar1Rst = 10'd150;
  localparam logic [RunW-1:0]  DeadRst = 8'd4;

  // Bar counts
  localparam logic [BarsW-1:0] Bars0 = 3'd0;
  localparam logic [BarsW-1:0] Bars1 = 3'd1;
  localparam logic [BarsW-1:0] Bars2 = 3'd2;
  localparam logic [BarsW-1:0] Bars3 = 3'd3;
  localparam logic [BarsW-1:0] Bars4 = 3'd4;

  typedef enum logic [FuncW-1:0] {
    FUNC_SEND_DONE  = 2'd0,
    FUNC_CONN_START = 2'd1,
    FUNC_CONNECTED  = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIRED_MODE = 3'd0,
    CFG_BAR4_FLOOR = 3'd1,
    CFG_BAR3_FLOOR = 3'd2,
    CFG_BAR2_FLOOR = 3'd3,
    CFG_BAR1_FLOOR = 3'd4,
    CFG_DEAD_LIMIT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             wired_mode;
    logic [QualW-1:0] bar4_floor;
    logic [QualW-1:0] bar3_floor;
    logic [QualW-1:0] bar2_floor;
    logic [QualW-1:0] bar1_floor;
    logic [RunW-1:0]  dead_limit;
  } lqm_cfg_t;

  typedef struct packed {
    logic [QualW-1:0] quality_avg;
    logic [RunW-1:0]  fail_run;
    logic             link_up;
  } lqm_state_t;

  typedef struct packed {
    logic [QualW-1:0] quality;
    logic [BarsW-1:0] bars;
    logic             link_dead;
  } lqm_result_t;

endpackage

// ===== design/lqm_if.sv =====
// ----------------------------------------------------------------------------
// lqm_if: valid/ready channels of the link quality monitor
// Event channel (lqm_in_if) and report channel (lqm_out_if).
// ----------------------------------------------------------------------------
interface lqm_in_if;
  logic                        valid;
  logic                        ready;
  logic [lqm_pkg::FuncW-1:0]   func;
  logic [lqm_pkg::MacW-1:0]    dest_mac;
  logic                        ack_ok;

  modport source (output valid, output func, output dest_mac, output ack_ok, input ready);
  modport sink   (input valid, input func, input dest_mac, input ack_ok, output ready);
endinterface

interface lqm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lqm_pkg::QualW-1:0]   quality;
  logic [lqm_pkg::BarsW-1:0]   bars;
  logic                        link_dead;

  modport source (output valid, output quality, output bars, output link_dead, input ready);
  modport sink   (input valid, input quality, input bars, input link_dead, output ready);
endinterface

// ===== design/lqm_step.sv =====
// ----------------------------------------------------------------------------
// lqm_step: per-event update of the link quality monitor
// Computes the next quality/failure/link state and the report for one event.
// ----------------------------------------------------------------------------
module lqm_step (
  input  lqm_pkg::lqm_cfg_t           cfg_i,
  input  lqm_pkg::lqm_state_t         state_i,
  input  logic [lqm_pkg::FuncW-1:0]   func_i,
  input  logic [lqm_pkg::MacW-1:0]    dest_mac_i,
  input  logic                        ack_ok_i,
  output lqm_pkg::lqm_state_t         state_o,
  output lqm_pkg::lqm_result_t        result_o
);
  import lqm_pkg::*;

  logic [QualW-1:0] gain;
  logic [QualW:0]   loss_sum;
  logic [QualW-1:0] loss;
  logic [QualW-1:0] q_ema;
  logic [RunW-1:0]  run_inc;
  logic             is_bcast;
  lqm_state_t       nxt;

  // Moving average step, weight 1/8, floor rounding in both directions
  assign gain     = (QualFull - state_i.quality_avg) >> 3;
  assign loss_sum = {1'b0, state_i.quality_avg} + (QualW+1)'(7);
  assign loss     = QualW'(loss_sum >> 3);
  assign q_ema    = ack_ok_i ? (state_i.quality_avg + gain) : (state_i.quality_avg - loss);

  // Failure run, saturating
  assign run_inc  = (state_i.fail_run == RunMax) ? state_i.fail_run
                                                 : state_i.fail_run + RunW'(1);
  assign is_bcast = &dest_mac_i;

  // Next state by event kind
  always_comb begin
    nxt = state_i;
    case (func_i)
      FUNC_SEND_DONE: begin
        if (!is_bcast) begin
          nxt.quality_avg = q_ema;
          nxt.fail_run    = ack_ok_i ? '0 : run_inc;
        end
      end
      FUNC_CONN_START: begin
        nxt.link_up = 1'b0;
      end
      FUNC_CONNECTED: begin
        nxt.quality_avg = QualFull;
        nxt.fail_run    = '0;
        nxt.link_up     = 1'b1;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o = nxt;

  // Report from the updated state
  always_comb begin
    result_o.quality = nxt.quality_avg;
    if (cfg_i.wired_mode || !nxt.link_up) begin
      result_o.bars = Bars0;
    end else if (nxt.quality_avg >= cfg_i.bar4_floor) begin
      result_o.bars = Bars4;
    end else if (nxt.quality_avg >= cfg_i.bar3_floor) begin
      result_o.bars = Bars3;
    end else if (nxt.quality_avg >= cfg_i.bar2_floor) begin
      result_o.bars = Bars2;
    end else if (nxt.quality_avg >= cfg_i.bar1_floor) begin
      result_o.bars = Bars1;
    end else begin
      result_o.bars = Bars0;
    end
    result_o.link_dead = !cfg_i.wired_mode && (nxt.fail_run >= cfg_i.dead_limit);
  end

endmodule

// ===== design/link_quality_monitor.sv =====
// ----------------------------------------------------------------------------
// link_quality_monitor: moving-average link quality, bars and dead detection
// One report per event, taken after the event updates the link state.
// ----------------------------------------------------------------------------
// Report timing: a report is valid in the cycle after its event is accepted.
// Throughput: one event per cycle; the report register is the only stage and
// takes a new event whenever it is empty or its report is taken that cycle.
// Reset: quality 1000, failure run 0, link down, registers at their defaults,
// report register empty. No clearing pass.
module link_quality_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lqm_in_if.sink                        in_ch,
  lqm_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [lqm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lqm_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lqm_pkg::*;

  lqm_cfg_t    cfg_q;
  lqm_state_t  state_q;
  lqm_state_t  state_d;
  lqm_result_t result_d;
  lqm_result_t result_q;
  logic        out_valid_q;
  logic        in_ready;
  logic        in_acc;

  // Handshake: accept while the report register is empty or draining
  assign in_ready     = !out_valid_q || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wired_mode <= 1'b1;
      cfg_q.bar4_floor <= Bar4Rst;
      cfg_q.bar3_floor <= Bar3Rst;
      cfg_q.bar2_floor <= Bar2Rst;
      cfg_q.bar1_floor <= Bar1Rst;
      cfg_q.dead_limit <= DeadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIRED_MODE: cfg_q.wired_mode <= cfg_wdata_i[0];
        CFG_BAR4_FLOOR: cfg_q.bar4_floor <= cfg_wdata_i[QualW-1:0];
        CFG_BAR3_FLOOR: cfg_q.bar3_floor <= cfg_wdata_i[QualW-1:0];
        CFG_BAR2_FLOOR: cfg_q.bar2_floor <= cfg_wdata_i[QualW-1:0];
        CFG_BAR1_FLOOR: cfg_q.bar1_floor <= cfg_wdata_i[QualW-1:0];
        CFG_DEAD_LIMIT: cfg_q.dead_limit <= cfg_wdata_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // Event update
  lqm_step u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .func_i     (in_ch.func),
    .dest_mac_i (in_ch.dest_mac),
    .ack_ok_i   (in_ch.ack_ok),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // Link state and report valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.quality_avg <= QualFull;
      state_q.fail_run    <= '0;
      state_q.link_up     <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Report payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      result_q <= result_d;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.quality   = result_q.quality;
  assign out_ch.bars      = result_q.bars;
  assign out_ch.link_dead = result_q.link_dead;

endmodule

// ===== design/lqm_checker.sv =====
// ----------------------------------------------------------------------------
// lqm_checker: port-level checks of the link quality monitor
// Watches the event and report channels; bound to the top level.
// ----------------------------------------------------------------------------
module lqm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [lqm_pkg::QualW-1:0]    quality_i,
  input logic [lqm_pkg::BarsW-1:0]    bars_i
);
  import lqm_pkg::*;

  // A stalled report holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quality_i) && $stable(bars_i))
    else $error("report changed while stalled");

  // Every accepted event yields a report in the next cycle
  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted event without report");

  // A taken report with no new event leaves the channel empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("report repeated");

  // Quality and bars stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (quality_i <= QualFull) && (bars_i <= Bars4))
    else $error("report out of range");

endmodule

bind link_quality_monitor lqm_checker u_lqm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .quality_i   (out_ch.quality),
  .bars_i      (out_ch.bars)
);
